// ===== design/dmc_pkg.sv =====
// Shared types and codes for the door motion controller.
`timescale 1ns / 1ps

package dmc_pkg;

  localparam int REQ_W    = 3;
  localparam int DS_W     = 3;
  localparam int PHASE_W  = 3;
  localparam int TIMER_W  = 16;
  localparam int MARGIN_W = 12;
  localparam int TRAVEL_W = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_MARGIN  = 2'd1;

  localparam logic [TIMER_W-1:0]  STUCK_TIMEOUT_RST = 16'd2000;
  localparam logic [MARGIN_W-1:0] CALIB_MARGIN_RST  = 12'd100;
  localparam logic [TIMER_W-1:0]  TIMER_MAX         = 16'hFFFF;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_OPEN  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CLOSE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_STOP  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CALIB = 3'd4;

  // Motion phases.
  localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_MARGIN = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DOWN   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_UP     = 3'd3;
  localparam logic [PHASE_W-1:0] PH_OPEN   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_CLOSE  = 3'd5;

  // Door states as reported.
  localparam logic [DS_W-1:0] DS_IDLE    = 3'd0;
  localparam logic [DS_W-1:0] DS_OPENING = 3'd1;
  localparam logic [DS_W-1:0] DS_OPENED  = 3'd2;
  localparam logic [DS_W-1:0] DS_CLOSING = 3'd3;
  localparam logic [DS_W-1:0] DS_CLOSED  = 3'd4;

  typedef struct packed {
    logic [TIMER_W-1:0]  stuck_timeout_ms;
    logic [MARGIN_W-1:0] calib_margin_steps;
  } cfg_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             upper_pressed;
    logic             lower_pressed;
    logic             encoder_moved;
  } item_t;

  typedef struct packed {
    logic                step_up;
    logic                step_down;
    logic [DS_W-1:0]     door_state;
    logic                is_moving;
    logic                is_calibrated;
    logic                is_stuck;
    logic [TRAVEL_W-1:0] travel_steps;
  } result_t;

endpackage

// ===== design/dmc_req_if.sv =====
// Request channel: one tick item with command and sensor levels.
`timescale 1ns / 1ps

interface dmc_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic       upper_pressed;
  logic       lower_pressed;
  logic       encoder_moved;

  modport source (
    output valid, req_type, upper_pressed, lower_pressed, encoder_moved,
    input  ready
  );
  modport sink (
    input  valid, req_type, upper_pressed, lower_pressed, encoder_moved,
    output ready
  );
endinterface

// ===== design/dmc_rsp_if.sv =====
// Response channel: motor steps and door status after each tick.
`timescale 1ns / 1ps

interface dmc_rsp_if;
  logic        valid;
  logic        ready;
  logic        step_up;
  logic        step_down;
  logic [2:0]  door_state;
  logic        is_moving;
  logic        is_calibrated;
  logic        is_stuck;
  logic [15:0] travel_steps;

  modport source (
    output valid, step_up, step_down, door_state, is_moving, is_calibrated,
           is_stuck, travel_steps,
    input  ready
  );
  modport sink (
    input  valid, step_up, step_down, door_state, is_moving, is_calibrated,
           is_stuck, travel_steps,
    output ready
  );
endinterface

// ===== design/dmc_cfg_regs.sv =====
// Configuration registers: stuck timeout and calibration margin.
`timescale 1ns / 1ps

module dmc_cfg_regs import dmc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stuck_timeout_ms   <= STUCK_TIMEOUT_RST;
      cfg.calib_margin_steps <= CALIB_MARGIN_RST;
    end else if (wr_en) begin
      unique case (index)
        CFG_STUCK_TIMEOUT: cfg.stuck_timeout_ms   <= data[TIMER_W-1:0];
        CFG_CALIB_MARGIN:  cfg.calib_margin_steps <= data[MARGIN_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

endmodule

// ===== design/dmc_engine.sv =====
// Door state, watchdog and step counters with the per-tick update logic.
`timescale 1ns / 1ps

module dmc_engine import dmc_pkg::*; #(
  parameter int STEP_COUNT_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  localparam int LimW = (STEP_COUNT_BITS > TRAVEL_W) ? TRAVEL_W : STEP_COUNT_BITS;
  localparam int CntW = (LimW < MARGIN_W) ? MARGIN_W : LimW;
  localparam logic [CntW-1:0] CountLimit = CntW'((33'd1 << LimW) - 33'd1);

  logic [PHASE_W-1:0] phase, phase_next, cmd_phase;
  logic [DS_W-1:0]    door_st, door_st_next, cmd_door_st;
  logic               moving, moving_next, cmd_moving;
  logic               calibrated, calibrated_next;
  logic               stuck, stuck_next;
  logic [TIMER_W-1:0] idle_cnt, idle_cnt_next, cmd_idle_cnt;
  logic [CntW-1:0]    step_cnt, step_cnt_next, cmd_step_cnt;
  logic [CntW-1:0]    travel, travel_next;

  logic [TIMER_W-1:0] wd_cnt;
  logic               wd_hit;
  logic               su, sd;

  // Apply the command first.
  always_comb begin
    cmd_phase    = phase;
    cmd_door_st  = door_st;
    cmd_moving   = moving;
    cmd_idle_cnt = idle_cnt;
    cmd_step_cnt = step_cnt;
    unique case (item.req_type)
      REQ_OPEN: begin
        cmd_phase    = PH_OPEN;
        cmd_door_st  = DS_OPENING;
        cmd_moving   = 1'b1;
        cmd_idle_cnt = '0;
      end
      REQ_CLOSE: begin
        cmd_phase    = PH_CLOSE;
        cmd_door_st  = DS_CLOSING;
        cmd_moving   = 1'b1;
        cmd_idle_cnt = '0;
      end
      REQ_STOP: begin
        cmd_phase    = PH_IDLE;
        cmd_moving   = 1'b0;
        cmd_idle_cnt = '0;
      end
      REQ_CALIB: begin
        cmd_moving   = 1'b1;
        cmd_idle_cnt = '0;
        if (item.lower_pressed && (cfg.calib_margin_steps != '0)) begin
          cmd_phase    = PH_MARGIN;
          cmd_step_cnt = CntW'(cfg.calib_margin_steps);
        end else begin
          cmd_phase = PH_DOWN;
        end
      end
      default: ;  // tick only, unknown codes too
    endcase
  end

  // Watchdog candidate count for a driving tick.
  assign wd_cnt = item.encoder_moved ? '0 :
                  ((cmd_idle_cnt == TIMER_MAX) ? cmd_idle_cnt
                                               : cmd_idle_cnt + TIMER_W'(1));
  assign wd_hit = (wd_cnt >= cfg.stuck_timeout_ms);

  // Then advance the active phase by at most one step.
  always_comb begin
    phase_next      = cmd_phase;
    door_st_next    = cmd_door_st;
    moving_next     = cmd_moving;
    calibrated_next = calibrated;
    stuck_next      = stuck;
    idle_cnt_next   = cmd_idle_cnt;
    step_cnt_next   = cmd_step_cnt;
    travel_next     = travel;
    su              = 1'b0;
    sd              = 1'b0;

    unique case (cmd_phase)
      PH_OPEN, PH_CLOSE, PH_DOWN, PH_UP: begin
        if ((cmd_phase == PH_OPEN) && item.upper_pressed) begin
          door_st_next = DS_OPENED;
          moving_next  = 1'b0;
          phase_next   = PH_IDLE;
        end else if ((cmd_phase == PH_CLOSE) && item.lower_pressed) begin
          door_st_next = DS_CLOSED;
          moving_next  = 1'b0;
          phase_next   = PH_IDLE;
        end else if ((cmd_phase == PH_DOWN) && item.lower_pressed) begin
          phase_next    = PH_UP;
          step_cnt_next = '0;
        end else if ((cmd_phase == PH_UP) && item.upper_pressed) begin
          travel_next     = cmd_step_cnt;
          calibrated_next = 1'b1;
          stuck_next      = 1'b0;
          door_st_next    = DS_OPENED;
          moving_next     = 1'b0;
          phase_next      = PH_IDLE;
        end else if (wd_hit) begin
          moving_next     = 1'b0;
          stuck_next      = 1'b1;
          calibrated_next = 1'b0;
          phase_next      = PH_IDLE;
          idle_cnt_next   = '0;
        end else begin
          idle_cnt_next = wd_cnt;
          su = (cmd_phase == PH_OPEN) || (cmd_phase == PH_UP);
          sd = (cmd_phase == PH_CLOSE) || (cmd_phase == PH_DOWN);
          if ((cmd_phase == PH_UP) && (cmd_step_cnt < CountLimit)) begin
            step_cnt_next = cmd_step_cnt + CntW'(1);
          end
        end
      end
      PH_MARGIN: begin
        su = 1'b1;
        if (cmd_step_cnt != '0) begin
          step_cnt_next = cmd_step_cnt - CntW'(1);
        end
        if (step_cnt_next == '0) begin
          phase_next = PH_DOWN;
        end
      end
      default: begin
        phase_next    = PH_IDLE;
        moving_next   = 1'b0;
        idle_cnt_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      door_st    <= DS_IDLE;
      moving     <= 1'b0;
      calibrated <= 1'b0;
      stuck      <= 1'b0;
      idle_cnt   <= '0;
      step_cnt   <= '0;
      travel     <= '0;
    end else if (en) begin
      phase      <= phase_next;
      door_st    <= door_st_next;
      moving     <= moving_next;
      calibrated <= calibrated_next;
      stuck      <= stuck_next;
      idle_cnt   <= idle_cnt_next;
      step_cnt   <= step_cnt_next;
      travel     <= travel_next;
    end
  end

  always_comb begin
    res.step_up       = su;
    res.step_down     = sd;
    res.door_state    = door_st_next;
    res.is_moving     = moving_next;
    res.is_calibrated = calibrated_next;
    res.is_stuck      = stuck_next;
    res.travel_steps  = TRAVEL_W'(travel_next);
  end

endmodule

// ===== design/door_motion_controller_top.sv =====
// Top level of the door motion controller: input stage, engine, result stage.
// A request is captured in the input register and its response in the result
//   register; a stalled result stage holds the item in the input stage.
// Throughput: one tick item per cycle unless rsp.ready stalls; the tick update
//   is one pass through the engine logic between input and result registers.
// Reset (rst, synchronous): door idle, not moving, uncalibrated, not stuck,
//   counters zero, timeout 2000 and calibration margin 100.
`timescale 1ns / 1ps

module door_motion_controller_top import dmc_pkg::*; #(
  parameter int STEP_COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  dmc_req_if.sink               req,
  dmc_rsp_if.source             rsp
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    advance;
  result_t eng_res;
  result_t out_res;
  logic    out_valid;

  dmc_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // Move the held item through the engine whenever the result stage
  // is empty or its content is being transferred out this cycle.
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  // Input stage: capture a request on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.req_type      <= req.req_type;
      in_item.upper_pressed <= req.upper_pressed;
      in_item.lower_pressed <= req.lower_pressed;
      in_item.encoder_moved <= req.encoder_moved;
    end
  end

  // Engine: applies the command, runs the phase and watchdog, commits
  // state only when the item advances.
  dmc_engine #(
    .STEP_COUNT_BITS (STEP_COUNT_BITS)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .item (in_item),
    .cfg  (cfg),
    .res  (eng_res)
  );

  // Result stage: hold the response until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= eng_res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.step_up       = out_res.step_up;
  assign rsp.step_down     = out_res.step_down;
  assign rsp.door_state    = out_res.door_state;
  assign rsp.is_moving     = out_res.is_moving;
  assign rsp.is_calibrated = out_res.is_calibrated;
  assign rsp.is_stuck      = out_res.is_stuck;
  assign rsp.travel_steps  = out_res.travel_steps;

  // The motor never gets both directions in one tick.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.step_up && out_res.step_down))
    else $error("step up and step down issued together");

  // Any step belongs to a motion that is still in progress.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.step_up || out_res.step_down)) |-> out_res.is_moving)
    else $error("step issued while not moving");

  // Stuck clears calibration and calibration clears stuck.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.is_stuck && out_res.is_calibrated))
    else $error("stuck and calibrated reported together");

  // An item waiting on a full, stalled result stage stays in the input stage.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !rsp.ready) |=> in_valid)
    else $error("input item lost under stall");

endmodule
